// ===== rtl/core/bvsm_pkg.sv =====
package bvsm_pkg;

  localparam int TABLE_POINTS = 12;
  localparam int SEGMENTS = TABLE_POINTS - 1;
  localparam int MV_W = 16;
  localparam int SOC_W = 14;
  localparam int GAIN_W = 20;
  localparam int SPAN_W = 13;
  localparam int QUO_W = 10;
  localparam int ACC_W = 36;
  localparam int OPND_W = SPAN_W + QUO_W;
  localparam int MPL_W = 16;
  localparam int STEP_W = 4;
  localparam int SEG_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(73620);
  localparam logic [MV_W-1:0] MIN_MV_RESET = MV_W'(32000);

  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE = 1'b1;

  localparam logic [STEP_W-1:0] MUL_LAST_STEP = STEP_W'(MPL_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(QUO_W - 1);

  localparam logic [MV_W-1:0] TABLE_MV [TABLE_POINTS] = '{
    16'd30000, 16'd34500, 16'd36800, 16'd37400, 16'd37700, 16'd37900,
    16'd38200, 16'd38700, 16'd39200, 16'd39800, 16'd40600, 16'd42000
  };

  localparam logic [SOC_W-1:0] TABLE_SOC [TABLE_POINTS] = '{
    14'd0, 14'd500, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
    14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000, 14'd10000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_MV,
    ST_SAT,
    ST_SEG,
    ST_MUL_SOC,
    ST_DIV,
    ST_OUT
  } state_t;

  // The segment is the last table point at or below the voltage, clamped so
  // that the top end point falls in the last segment.
  function automatic logic [SEG_W-1:0] seg_of(input logic [MV_W-1:0] mv);
    logic [SEG_W-1:0] seg;
    seg = '0;
    for (int i = 1; i < SEGMENTS; i++) begin
      if (mv >= TABLE_MV[i]) begin
        seg = SEG_W'(i);
      end
    end
    return seg;
  endfunction

  function automatic logic [SPAN_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
    logic [MV_W-1:0] diff;
    diff = '0;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (seg == SEG_W'(i)) begin
        diff = TABLE_MV[i+1] - TABLE_MV[i];
      end
    end
    return diff[SPAN_W-1:0];
  endfunction

  function automatic logic [SOC_W-1:0] seg_rise(input logic [SEG_W-1:0] seg);
    logic [SOC_W-1:0] diff;
    diff = '0;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (seg == SEG_W'(i)) begin
        diff = TABLE_SOC[i+1] - TABLE_SOC[i];
      end
    end
    return diff;
  endfunction

  function automatic logic [MV_W-1:0] seg_base_mv(input logic [SEG_W-1:0] seg);
    logic [MV_W-1:0] base;
    base = '0;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (seg == SEG_W'(i)) begin
        base = TABLE_MV[i];
      end
    end
    return base;
  endfunction

  function automatic logic [SOC_W-1:0] seg_base_soc(input logic [SEG_W-1:0] seg);
    logic [SOC_W-1:0] base;
    base = '0;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (seg == SEG_W'(i)) begin
        base = TABLE_SOC[i];
      end
    end
    return base;
  endfunction

endpackage

// ===== rtl/core/battery_voltage_soc_monitor.sv =====
// Battery voltage and state-of-charge monitor. Every conversion beat accepted
// while idle is added to a saturating sum; a failed conversion still counts.
// The beat that completes a group of SAMPLES_PER_READING conversions starts the
// reading, and the input stalls until the reading has moved to the output
// register (16 multiply steps for the voltage, 16 for the interpolation
// product, 10 restoring divide steps and the saturation, segment lookup and
// output states), all on one shared 36-bit add/subtract unit, plus any wait
// for the output register to empty. Configuration writes are always accepted.
module battery_voltage_soc_monitor
  import bvsm_pkg::*;
#(
  parameter int SAMPLES_PER_READING = 10,
  parameter int ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [11:0]           adc_sample,
  input  logic                  conversion_ok,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MV_W-1:0]       voltage_mv,
  output logic [SOC_W-1:0]      percent_hundredths,
  output logic                  out_of_range,
  output logic                  low_voltage,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_READING - 1);
  localparam logic [11:0] SAMPLE_MASK =
    (ADC_BITS >= 12) ? 12'hFFF : 12'((1 << ADC_BITS) - 1);

  state_t state;
  state_t state_next;

  logic [GAIN_W-1:0] voltage_gain;
  logic [MV_W-1:0]   min_voltage_mv;
  logic [MV_W-1:0]   sample_sum;
  logic [CNT_W-1:0]  sample_count;

  logic [ACC_W-1:0]  acc;
  logic [OPND_W-1:0] opnd;
  logic [MPL_W-1:0]  mplier;
  logic [STEP_W-1:0] step;
  logic [MV_W-1:0]   mv;
  logic [SEG_W-1:0]  seg;
  logic              in_span;
  logic              low_flag;

  logic [ACC_W-1:0]  au_a;
  logic [ACC_W-1:0]  au_b;
  logic              au_cin;
  logic [ACC_W:0]    au_sum;

  logic              in_beat;
  logic              out_free;
  logic [MV_W-1:0]   sum_sat;
  logic [SEG_W-1:0]  seg_now;

  assign in_beat   = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign seg_now   = seg_of(mv);

  assign au_sum = {1'b0, au_a} + {1'b0, au_b} + {{ACC_W{1'b0}}, au_cin};

  assign sum_sat = (au_sum[ACC_W-1:MV_W] != '0) ? {MV_W{1'b1}} : au_sum[MV_W-1:0];

  always_comb begin
    state_next = state;
    au_a   = '0;
    au_b   = '0;
    au_cin = 1'b0;
    case (state)
      ST_IDLE: begin
        au_a = {{(ACC_W-MV_W){1'b0}}, sample_sum};
        au_b = conversion_ok ? {{(ACC_W-12){1'b0}}, adc_sample & SAMPLE_MASK} : '0;
        if (in_beat && sample_count == LAST_COUNT) begin
          state_next = ST_MUL_MV;
        end
      end
      ST_MUL_MV, ST_MUL_SOC: begin
        au_a = {acc[ACC_W-2:0], 1'b0};
        au_b = mplier[MPL_W-1] ? {{(ACC_W-OPND_W){1'b0}}, opnd} : '0;
        if (step == MUL_LAST_STEP) begin
          state_next = (state == ST_MUL_MV) ? ST_SAT : ST_DIV;
        end
      end
      ST_SAT: begin
        state_next = ST_SEG;
      end
      ST_SEG: begin
        au_a   = {{(ACC_W-MV_W){1'b0}}, mv};
        au_b   = ~{{(ACC_W-MV_W){1'b0}}, seg_base_mv(seg_now)};
        au_cin = 1'b1;
        state_next = ST_MUL_SOC;
      end
      ST_DIV: begin
        au_a   = acc;
        au_b   = ~{{(ACC_W-OPND_W){1'b0}}, opnd};
        au_cin = 1'b1;
        if (step == DIV_LAST_STEP) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        au_a = {{(ACC_W-SOC_W){1'b0}}, seg_base_soc(seg)};
        au_b = {{(ACC_W-QUO_W){1'b0}}, mplier[QUO_W-1:0]};
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_gain   <= GAIN_RESET;
      min_voltage_mv <= MIN_MV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VOLTAGE_GAIN: voltage_gain   <= cfg_data;
        REG_MIN_VOLTAGE:  min_voltage_mv <= cfg_data[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (in_beat) begin
      if (sample_count == LAST_COUNT) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_sat;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        acc    <= '0;
        opnd   <= {{(OPND_W-GAIN_W){1'b0}}, voltage_gain};
        mplier <= sum_sat;
        step   <= '0;
      end
      ST_MUL_MV: begin
        acc    <= au_sum[ACC_W-1:0];
        mplier <= {mplier[MPL_W-2:0], 1'b0};
        step   <= step + 1'b1;
      end
      ST_SAT: begin
        mv <= (acc[ACC_W-1:MV_W+MV_W] != '0) ? {MV_W{1'b1}} : acc[MV_W+MV_W-1:MV_W];
      end
      ST_SEG: begin
        seg      <= seg_now;
        in_span  <= (mv >= TABLE_MV[0]) && (mv <= TABLE_MV[TABLE_POINTS-1]);
        low_flag <= (mv < min_voltage_mv);
        acc      <= '0;
        opnd     <= {{(OPND_W-SPAN_W){1'b0}}, au_sum[SPAN_W-1:0]};
        mplier   <= {{(MPL_W-SOC_W){1'b0}}, seg_rise(seg_now)};
        step     <= '0;
      end
      ST_MUL_SOC: begin
        acc <= au_sum[ACC_W-1:0];
        if (step == MUL_LAST_STEP) begin
          opnd   <= {seg_span(seg), {QUO_W-1{1'b0}}, 1'b0} >> 1;
          mplier <= '0;
          step   <= '0;
        end else begin
          mplier <= {mplier[MPL_W-2:0], 1'b0};
          step   <= step + 1'b1;
        end
      end
      ST_DIV: begin
        if (au_sum[ACC_W]) begin
          acc <= au_sum[ACC_W-1:0];
        end
        mplier <= {mplier[MPL_W-2:0], au_sum[ACC_W]};
        opnd   <= opnd >> 1;
        step   <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      voltage_mv         <= mv;
      percent_hundredths <= in_span ? au_sum[SOC_W-1:0] : '0;
      out_of_range       <= !in_span;
      low_voltage        <= low_flag;
    end
  end

endmodule

// ===== rtl/core/bvsm_checker.sv =====
module bvsm_checker
  import bvsm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MV_W-1:0]   voltage_mv,
  input logic [SOC_W-1:0]  percent_hundredths,
  input logic              out_of_range,
  input logic              low_voltage
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result beat present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(voltage_mv)
      && $stable(percent_hundredths) && $stable(out_of_range) && $stable(low_voltage))
    else $error("stalled result beat changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> percent_hundredths == '0)
    else $error("charge nonzero while out of range");

  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> voltage_mv >= TABLE_MV[0]
      && voltage_mv <= TABLE_MV[TABLE_POINTS-1])
    else $error("in-range flag disagrees with voltage");

  a_soc_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> percent_hundredths <= TABLE_SOC[TABLE_POINTS-1])
    else $error("charge above full scale");

endmodule

bind battery_voltage_soc_monitor bvsm_checker u_bvsm_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .voltage_mv         (voltage_mv),
  .percent_hundredths (percent_hundredths),
  .out_of_range       (out_of_range),
  .low_voltage        (low_voltage)
);

// ===== verif/battery_voltage_soc_monitor_tb.sv =====
module battery_voltage_soc_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bvsm_pkg::*;

  localparam int READING_LEN = 10;
  localparam int SAMPLE_MAX = 4095;
  localparam int MAX_SUM = READING_LEN * SAMPLE_MAX;
  localparam int TABLE_LAST = 11;
  localparam int CHARGE_MV [12] = '{
    30000, 34500, 36800, 37400, 37700, 37900,
    38200, 38700, 39200, 39800, 40600, 42000
  };
  localparam int CHARGE_SOC [12] = '{
    0, 500, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000
  };
  localparam int PHASES = 16;
  localparam int GROUPS_PER_PHASE = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [SOC_W-1:0] soc;
    logic             oor;
    logic             low;
  } reading_t;

  class charge_scoreboard;
    reading_t        readings_due [$];
    logic [GAIN_W-1:0] gain;
    logic [MV_W-1:0]   min_mv;
    logic [MV_W-1:0]   sum;
    int                count;
    int                errors;

    function new();
      gain = GAIN_W'(73620);
      min_mv = MV_W'(32000);
      sum = '0;
      count = 0;
      errors = 0;
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_VOLTAGE_GAIN) begin
        gain = val[GAIN_W-1:0];
      end else if (idx == REG_MIN_VOLTAGE) begin
        min_mv = val[MV_W-1:0];
      end
    endfunction

    function logic [SOC_W-1:0] charge_of_mv(logic [MV_W-1:0] mv);
      int i;
      int v;
      v = int'(mv);
      if (v >= CHARGE_MV[TABLE_LAST]) begin
        return SOC_W'(CHARGE_SOC[TABLE_LAST]);
      end
      for (i = 0; i < TABLE_LAST; i++) begin
        if (v >= CHARGE_MV[i] && v < CHARGE_MV[i+1]) begin
          return SOC_W'(CHARGE_SOC[i] + ((v - CHARGE_MV[i]) *
                 (CHARGE_SOC[i+1] - CHARGE_SOC[i])) / (CHARGE_MV[i+1] - CHARGE_MV[i]));
        end
      end
      return '0;
    endfunction

    function void note_conversion(logic [11:0] smp, logic ok);
      logic [16:0]     acc;
      logic [55:0]     prod;
      logic [MV_W-1:0] mv;
      logic            in_span;
      reading_t        r;
      if (ok) begin
        acc = {1'b0, sum} + {5'b0, smp};
        sum = acc[16] ? '1 : acc[15:0];
      end
      if (count + 1 < READING_LEN) begin
        count++;
        return;
      end
      count = 0;
      prod = (56'(sum) * 56'(gain)) >> 16;
      mv = (prod > 56'(16'hFFFF)) ? 16'hFFFF : prod[15:0];
      sum = '0;
      in_span = (int'(mv) >= CHARGE_MV[0]) && (int'(mv) <= CHARGE_MV[TABLE_LAST]);
      r.mv = mv;
      r.soc = in_span ? charge_of_mv(mv) : '0;
      r.oor = !in_span;
      r.low = (mv < min_mv);
      readings_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("tb: mismatch, %s", msg);
    endtask

    task check_reading(logic [MV_W-1:0] mv, logic [SOC_W-1:0] soc, logic oor, logic low);
      reading_t due;
      if (readings_due.size() == 0) begin
        report($sformatf("reading %0d mV arrived with none pending", mv));
        return;
      end
      due = readings_due.pop_front();
      if (mv !== due.mv) begin
        report($sformatf("voltage_mv %0d, predicted %0d", mv, due.mv));
      end
      if (soc !== due.soc) begin
        report($sformatf("percent_hundredths %0d at %0d mV, predicted %0d",
                         soc, due.mv, due.soc));
      end
      if (oor !== due.oor) begin
        report($sformatf("out_of_range %0b at %0d mV, predicted %0b", oor, due.mv, due.oor));
      end
      if (low !== due.low) begin
        report($sformatf("low_voltage %0b at %0d mV, predicted %0b", low, due.mv, due.low));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [11:0]           adc_sample;
  logic                  conversion_ok;
  logic                  out_valid;
  logic                  out_stall;
  logic [MV_W-1:0]       voltage_mv;
  logic [SOC_W-1:0]      percent_hundredths;
  logic                  out_of_range;
  logic                  low_voltage;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  charge_scoreboard sb;
  bit calm;
  bit hold_req;
  int stall_left;
  int idle_cycles;

  battery_voltage_soc_monitor #(
    .SAMPLES_PER_READING(READING_LEN),
    .ADC_BITS(12)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .adc_sample(adc_sample),
    .conversion_ok(conversion_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .voltage_mv(voltage_mv),
    .percent_hundredths(percent_hundredths),
    .out_of_range(out_of_range),
    .low_voltage(low_voltage),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(3, 1);
    end else if (r < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // The long hold-off is counted here so that the sender keeps offering beats
  // while the block backs up.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(5, 0) == 0) begin
        stall_left = idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_reading(voltage_mv, percent_hundredths, out_of_range, low_voltage);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(input logic [11:0] smp, input logic ok);
    int gap;
    in_valid <= 1'b1;
    adc_sample <= smp;
    conversion_ok <= ok;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_conversion(smp, ok);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Half of the groups aim their sum at a voltage of interest under the current gain:
  // table points and their neighbors, the span edges and the low threshold.
  task automatic send_group();
    logic [11:0] smp [READING_LEN];
    logic        okf [READING_LEN];
    int          kind;
    int          mv_goal;
    longint      want64;
    int          want;
    int          k;
    int          rem;
    int          left;
    int          lo;
    int          hi;
    int          i;
    logic [11:0] fill;
    kind = $urandom_range(9, 0);
    for (i = 0; i < READING_LEN; i++) begin
      smp[i] = 12'($urandom);
      okf[i] = ($urandom_range(9, 0) != 0);
    end
    if (kind == 9) begin
      for (i = 0; i < READING_LEN; i++) begin
        okf[i] = 1'($urandom);
      end
    end else if (kind == 8) begin
      fill = $urandom_range(1, 0) ? 12'hFFF : 12'h000;
      for (i = 0; i < READING_LEN; i++) begin
        smp[i] = fill;
      end
    end else if (kind >= 3) begin
      case ($urandom_range(7, 0))
        0, 1, 2, 3: mv_goal = CHARGE_MV[$urandom_range(TABLE_LAST, 0)] + $urandom_range(2, 0) - 1;
        4: mv_goal = $urandom_range(1, 0) ? 30000 - $urandom_range(1, 0)
                                          : 42000 + $urandom_range(1, 0);
        5: mv_goal = int'(sb.min_mv) + $urandom_range(2, 0) - 1;
        6: mv_goal = $urandom_range(65535, 0);
        default: mv_goal = $urandom_range(1, 0) ? 65535 : 0;
      endcase
      if (mv_goal < 0) begin
        mv_goal = 0;
      end
      if (sb.gain == 0) begin
        want = $urandom_range(MAX_SUM, 0);
      end else begin
        want64 = ((longint'(mv_goal) << 16) + longint'(sb.gain) - 1) / longint'(sb.gain);
        want = (want64 > MAX_SUM) ? MAX_SUM : int'(want64);
      end
      k = 0;
      for (i = 0; i < READING_LEN; i++) begin
        k += okf[i];
      end
      i = 0;
      while (k * SAMPLE_MAX < want) begin
        if (!okf[i]) begin
          okf[i] = 1'b1;
          k++;
        end
        i++;
      end
      rem = want;
      left = k;
      for (i = 0; i < READING_LEN; i++) begin
        if (okf[i]) begin
          lo = rem - SAMPLE_MAX * (left - 1);
          if (lo < 0) begin
            lo = 0;
          end
          hi = (rem < SAMPLE_MAX) ? rem : SAMPLE_MAX;
          smp[i] = 12'($urandom_range(hi, lo));
          rem -= int'(smp[i]);
          left--;
        end
      end
    end
    for (i = 0; i < READING_LEN; i++) begin
      send_beat(smp[i], okf[i]);
    end
  endtask

  initial begin
    int p;
    int g;
    logic [GAIN_W-1:0] gain_w;
    logic [MV_W-1:0]   min_w;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    adc_sample <= '0;
    conversion_ok <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_VOLTAGE_GAIN;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Full-scale group at the reset gain, then a group whose good beats
    // carry zero while the failed ones carry full scale.
    for (g = 0; g < READING_LEN; g++) begin
      send_beat(12'hFFF, 1'b1);
    end
    for (g = 0; g < READING_LEN; g++) begin
      send_beat(g[0] ? 12'h000 : 12'hFFF, g[0]);
    end
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin gain_w = GAIN_W'(73620); min_w = MV_W'(32000); end
        1: begin gain_w = GAIN_W'(65536); min_w = MV_W'(0); end
        2: begin gain_w = GAIN_W'(131072); min_w = MV_W'(65535); end
        3: begin gain_w = '0; min_w = MV_W'(32000); end
        4: begin gain_w = '1; min_w = MV_W'(40000); end
        5: begin gain_w = GAIN_W'(131072); min_w = MV_W'($urandom_range(44000, 28000)); end
        default: begin
          case ($urandom_range(3, 0))
            0: gain_w = GAIN_W'(131072);
            1: gain_w = GAIN_W'($urandom);
            default: gain_w = GAIN_W'($urandom_range(140000, 60000));
          endcase
          min_w = $urandom_range(1, 0) ? MV_W'($urandom_range(44000, 28000)) : MV_W'($urandom);
        end
      endcase
      program_reg(REG_VOLTAGE_GAIN, CFG_DATA_W'(gain_w));
      program_reg(REG_MIN_VOLTAGE, CFG_DATA_W'(min_w));
      calm = ($urandom_range(4, 0) == 0);
      for (g = 0; g < GROUPS_PER_PHASE; g++) begin
        if (p == 2 && g == 2) begin
          hold_req = 1'b1;
        end
        send_group();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
